@@ rtl/prot_pkg.sv @@
// ============================================================================
// Point rotation package
// Shared widths, register indexes, the quarter-wave sine table and lookup.
// ============================================================================
package prot_pkg;

   // Sine table resolution: 2^SINE_TABLE_BITS + 1 entries over a quarter wave.
   localparam int SINE_TABLE_BITS = 10;
   localparam int TAB_N           = 1 << SINE_TABLE_BITS;
   localparam int IDX_W           = SINE_TABLE_BITS + 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int COORD_W = 32;
   localparam int DIR_W   = 18;
   localparam int TRIG_W  = 18;
   localparam int ANGLE_W = 16;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_POINT_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE   = 3'd6;

   localparam logic signed [TRIG_W-1:0] ONE_Q16 = 18'sd65536;

   typedef logic [16:0] rom_type [0:TAB_N];

   // Settings that the datapath sees; the user keeps them stable while points stream (not enforced).
   typedef struct packed {
      logic [2:0][COORD_W-1:0] point;
      logic [2:0][DIR_W-1:0]   dir;
      logic [TRIG_W-1:0]       cos_val;
      logic [TRIG_W-1:0]       sin_val;
   } cfg_type;

   // Builds the table at elaboration with a truncated Taylor series in Q2.30.
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] q;
      for (int i = 0; i <= TAB_N; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
         term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
         term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
         term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
         term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
         term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
         term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
         q = (sum + 64'd8192) >> 14;
         if (q > 64'd65536) begin
            q = 64'd65536;
         end
         rom[i] = q[16:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Sine of a 16-bit turn fraction; low angle bits are dropped.
   function automatic logic [TRIG_W-1:0] sine_of(input logic [ANGLE_W-1:0] ang);
      logic [1:0]        quad;
      logic [IDX_W-1:0]  idx;
      logic [TRIG_W-1:0] val;
      quad = ang[15:14];
      idx  = IDX_W'(ang[13:0] >> (14 - SINE_TABLE_BITS));
      if (quad[0]) begin
         idx = IDX_W'(TAB_N) - idx;
      end
      val = {1'b0, SINE_ROM[idx]};
      return quad[1] ? (TRIG_W'(0) - val) : val;
   endfunction

endpackage

@@ rtl/prot_cfg.sv @@
// ============================================================================
// Point rotation settings
// Holds the line point and direction, and latches cosine and sine of the
// angle from the sine table when the angle register is written.
// ============================================================================
module prot_cfg import prot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_POINT_X: cfg_in.point[0] = csr_wdata;
            REG_POINT_Y: cfg_in.point[1] = csr_wdata;
            REG_POINT_Z: cfg_in.point[2] = csr_wdata;
            REG_DIR_X:   cfg_in.dir[0]   = csr_wdata[DIR_W-1:0];
            REG_DIR_Y:   cfg_in.dir[1]   = csr_wdata[DIR_W-1:0];
            REG_DIR_Z:   cfg_in.dir[2]   = csr_wdata[DIR_W-1:0];
            REG_ANGLE: begin
               cfg_in.sin_val = sine_of(csr_wdata[ANGLE_W-1:0]);
               cfg_in.cos_val = sine_of(csr_wdata[ANGLE_W-1:0] + 16'd16384);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point   <= '0;
         cfg_ff.dir     <= {ONE_Q16, {DIR_W{1'b0}}, {DIR_W{1'b0}}};
         cfg_ff.cos_val <= ONE_Q16;
         cfg_ff.sin_val <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/prot_pipe.sv @@
// ============================================================================
// Point rotation datapath
// Seven-stage pipeline applying the axis-rotation formula to one point per
// cycle, with a common stall driven by the output register.
// ============================================================================
module prot_pipe import prot_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_in_x,
   input  logic [COORD_W-1:0] req_in_y,
   input  logic [COORD_W-1:0] req_in_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_out_x,
   output logic [COORD_W-1:0] rsp_out_y,
   output logic [COORD_W-1:0] rsp_out_z
);

   localparam int NSTG = 7;

   logic            adv;
   logic [NSTG:1]   vld_ff;
   logic [NSTG:1]   vld_in;

   logic signed [32:0] q1_ff [3];
   logic signed [32:0] q2_ff [3];
   logic signed [32:0] q3_ff [3];
   logic signed [32:0] q4_ff [3];
   logic signed [32:0] q5_ff [3];
   logic signed [50:0] pd2_ff [3];
   logic signed [50:0] pa2_ff [3];
   logic signed [50:0] pb2_ff [3];
   logic signed [36:0] dot3_ff;
   logic signed [35:0] cr3_ff [3];
   logic signed [35:0] cr4_ff [3];
   logic signed [35:0] cr5_ff [3];
   logic signed [54:0] pu4_ff [3];
   logic signed [38:0] ax5_ff [3];
   logic signed [57:0] t1_ff [3];
   logic signed [50:0] t2_ff [3];
   logic signed [53:0] t3_ff [3];
   logic [COORD_W-1:0] out_ff [3];

   logic signed [36:0] dot_in;
   logic signed [52:0] dot_sum;
   logic signed [18:0] omc;
   logic signed [17:0] cos_s;
   logic signed [17:0] sin_s;

   // Clamp a wide signed sum to the 32-bit coordinate range.
   function automatic logic [COORD_W-1:0] sat32(input logic signed [43:0] v);
      if (v > 44'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -44'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[COORD_W-1:0];
   endfunction

   assign adv       = !vld_ff[NSTG] || rsp_ready;
   assign req_ready = adv;
   assign cos_s     = $signed(cfg.cos_val);
   assign sin_s     = $signed(cfg.sin_val);
   assign omc       = 19'sd65536 - 19'(cos_s);

   // Valid bits move together with the data whenever the output can drain.
   assign vld_in = adv ? {vld_ff[NSTG-1:1], req_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Projection onto the direction: sum of the three products, rounded.
   assign dot_sum = 53'(pd2_ff[0]) + 53'(pd2_ff[1]) + 53'(pd2_ff[2]) + 53'sd32768;
   assign dot_in  = 37'(dot_sum >>> 16);

   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 1: offset from the line point.
         q1_ff[0] <= 33'($signed(req_in_x)) - 33'($signed(cfg.point[0]));
         q1_ff[1] <= 33'($signed(req_in_y)) - 33'($signed(cfg.point[1]));
         q1_ff[2] <= 33'($signed(req_in_z)) - 33'($signed(cfg.point[2]));
         dot3_ff  <= dot_in;
         for (int i = 0; i < 3; i++) begin
            // Stage 2: dot and cross products.
            pd2_ff[i] <= 51'($signed(cfg.dir[i]) * q1_ff[i]);
            pa2_ff[i] <= 51'($signed(cfg.dir[(i + 1) % 3]) * q1_ff[(i + 2) % 3]);
            pb2_ff[i] <= 51'($signed(cfg.dir[(i + 2) % 3]) * q1_ff[(i + 1) % 3]);
            q2_ff[i]  <= q1_ff[i];
            // Stage 3: rounded cross product.
            cr3_ff[i] <= 36'((52'(pa2_ff[i]) - 52'(pb2_ff[i]) + 52'sd32768) >>> 16);
            q3_ff[i]  <= q2_ff[i];
            // Stage 4: direction scaled by the projection.
            pu4_ff[i] <= 55'($signed(cfg.dir[i]) * dot3_ff);
            cr4_ff[i] <= cr3_ff[i];
            q4_ff[i]  <= q3_ff[i];
            // Stage 5: round the axial component.
            ax5_ff[i] <= 39'((pu4_ff[i] + 55'sd32768) >>> 16);
            cr5_ff[i] <= cr4_ff[i];
            q5_ff[i]  <= q4_ff[i];
            // Stage 6: weight by (1 - cos), cos and sin.
            t1_ff[i]  <= 58'(ax5_ff[i] * omc);
            t2_ff[i]  <= 51'(q5_ff[i] * cos_s);
            t3_ff[i]  <= 54'(cr5_ff[i] * sin_s);
         end
         // Stage 7: sum, round, add the line point back and saturate.
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= sat32(44'(((59'(t1_ff[i]) + 59'(t2_ff[i]) + 59'(t3_ff[i])
                                   + 59'sd32768) >>> 16))
                               + 44'($signed(cfg.point[i])));
         end
      end
   end

   assign rsp_valid = vld_ff[NSTG];
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

   // A stall freezes every stage's valid bit.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   // An accepted request occupies the first stage next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[1])
      else $error("accepted request lost at pipeline entry");

   // A result either came from the stage before or was being held.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(vld_ff[NSTG-1]) || $past(rsp_valid && !rsp_ready)))
      else $error("result appeared without a source");

endmodule

@@ rtl/point_rotate_about_line_top.sv @@
// ============================================================================
// Point rotation about a line
// Rotates streamed Q16.16 points about a configured line by a set angle.
// ============================================================================
// Usage:
//   Requests carry one point (req_in_x/y/z) on a valid/ready channel; results
//   leave on the rsp_ channel, one per request, in order.
//   The line point, direction and angle are written through csr_wr_en, csr_index
//   and csr_wdata; the user must do so only while no request is in flight, as
//   the block does not enforce it. Writing the angle latches its cosine and
//   sine from the sine table in the same cycle. Throughput is one point per cycle
//   unless stalled: the seven register stages each hold an independent point.
//   The whole pipeline advances whenever the output register is empty or being
//   taken; when the receiver holds rsp_ready low with a result waiting, every
//   stage holds and req_ready drops, so nothing is lost or repeated.
//   Synchronous reset empties the pipeline and restores the line point to the
//   origin, the direction to +z and the angle to zero.
// ============================================================================
module point_rotate_about_line_top import prot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COORD_W-1:0]   req_in_x,
   input  logic [COORD_W-1:0]   req_in_y,
   input  logic [COORD_W-1:0]   req_in_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COORD_W-1:0]   rsp_out_x,
   output logic [COORD_W-1:0]   rsp_out_y,
   output logic [COORD_W-1:0]   rsp_out_z
);

   cfg_type cfg;

   // Settings and trig latch.
   prot_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Rotation datapath.
   prot_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in_x  (req_in_x),
      .req_in_y  (req_in_y),
      .req_in_z  (req_in_z),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z)
   );

endmodule
